[rtl/umad_pkg.sv]
// Package for the one-dimensional upstream/MPDATA advection block.
// Holds the command and result beat types, register codes, widths and the saturation helper.
// No dependencies.
package umad_pkg;

    // Storage and field widths.
    localparam int CELLS     = 1024;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int IDX_W     = 10;
    localparam int DATA_W    = 32;
    localparam int END_W     = 11;
    localparam int CFG_IDX_W = 2;

    // Arithmetic widths: operands, rounded products, accumulators, divider.
    localparam int OPND_W = 33;
    localparam int PROD_W = 49;
    localparam int ACC_W  = 52;
    localparam int QUO_W  = 48;
    localparam int REM_W  = 34;
    localparam int CNT_W  = 6;

    // Command codes; the last one is unused and ignored by the block.
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_STEP  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    // Result kinds.
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END   = 2'd3;

    // Configuration reset values.
    localparam logic [DATA_W-1:0] RST_SCALE = 32'd32768;
    localparam logic [DATA_W-1:0] RST_GAIN  = 32'd70779;
    localparam logic [IDX_W-1:0]  RST_START = 10'd0;
    localparam logic [END_W-1:0]  RST_END   = 11'd1024;

    localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

    // Command beat.
    typedef struct packed {
        logic [1:0]               opcode;
        logic [IDX_W-1:0]         cell_index;
        logic signed [DATA_W-1:0] tracer_in;
        logic signed [DATA_W-1:0] velocity_in;
    } t_cmd;

    // Result beat.
    typedef struct packed {
        logic                     result_kind;
        logic signed [DATA_W-1:0] tracer_out;
        logic                     saturated;
    } t_res;

    // Saturated value with its clip flag.
    typedef struct packed {
        logic                     clip;
        logic signed [DATA_W-1:0] val;
    } t_sat;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE, S_RD_OUT, S_DONE,
        S_P1_RD0, S_P1_RD1, S_P1_RD2, S_P1_CAP,
        S_A1, S_A2, S_A3, S_A4, S_A5, S_A6, S_A7, S_P1_NEXT,
        S_P2_RD0, S_P2_RD1, S_P2_RD2, S_P2_CAP,
        S_C1, S_C2, S_C3, S_DIV_R, S_DIV_L,
        S_C5, S_C6, S_C7, S_C8, S_C9, S_P2_NEXT
    } t_state;

    // Clip a wide signed value to signed 32 bits.
    function automatic t_sat sat32(input logic signed [ACC_W-1:0] x);
        t_sat s;
        s.clip = (x[ACC_W-1:DATA_W-1] != '0) && (x[ACC_W-1:DATA_W-1] != '1);
        if (s.clip) begin
            s.val = x[ACC_W-1] ? SAT_MIN : SAT_MAX;
        end else begin
            s.val = x[DATA_W-1:0];
        end
        return s;
    endfunction

endpackage

[rtl/upstream_mpdata_advection_1d.sv]
// Top level of the one-dimensional upstream advection block with MPDATA correction.
// Holds the cell memories, the sequencer, one shared multiplier and a bit-serial divider.
// Depends on umad_pkg.
//
//  Channel   Signals                              Direction  Handshake
//  command   start, busy, i_cmd                   in         taken when start && !busy
//  result    o_strobe, o_res                      out        one-cycle strobe, no back-pressure
//  config    i_cfg_we, i_cfg_idx, i_cfg_data      in         written when i_cfg_we is high
//
// A cell write is taken straight from the command; a read result passes the registered
// memory read and the output register. A step runs a first pass and a second pass over
// the cells; each cell of the second pass holds two 48-step divisions of the serial divider.
// Reset is synchronous and active low; the memories come up undefined until written.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
module upstream_mpdata_advection_1d
    import umad_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_cmd                 i_cmd,
    output logic                 o_strobe,
    output t_res                 o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_W-1:0]    i_cfg_data
);

    // Configuration registers.
    logic [DATA_W-1:0] r_scale, r_gain;
    logic [IDX_W-1:0]  r_start;
    logic [END_W-1:0]  r_end;

    // Sequencer and window registers.
    t_state r_state, n_state;
    logic [ADDR_W-1:0] r_i, n_i;
    logic signed [DATA_W-1:0] r_tm, r_tc, r_tp, n_tm, n_tc, n_tp;
    logic signed [DATA_W-1:0] r_um, r_uc, r_up, n_um, n_uc, n_up;
    logic signed [DATA_W-1:0] r_cr, r_cl, r_ra, r_la, n_cr, n_cl, n_ra, n_la;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic r_sat, n_sat;
    logic r_out_valid, n_out_valid;
    t_res r_out, n_out;

    // Memories and their registered read data.
    logic signed [DATA_W-1:0] tr_mem [CELLS];
    logic signed [DATA_W-1:0] ve_mem [CELLS];
    logic signed [DATA_W-1:0] up_mem [CELLS];
    logic signed [DATA_W-1:0] dr_mem [CELLS];
    logic signed [DATA_W-1:0] dl_mem [CELLS];
    logic signed [DATA_W-1:0] r_rd_t, r_rd_v, r_rd_u, r_rd_dr, r_rd_dl;

    logic [ADDR_W-1:0] rd_addr, tr_waddr, up_waddr;
    logic tr_we, ve_we, up_we, df_we;
    logic signed [DATA_W-1:0] tr_wdata, up_wdata;

    // Divider registers.
    logic [QUO_W-1:0]  r_dvd, r_quo, n_dvd, n_quo;
    logic [REM_W-1:0]  r_rem, n_rem;
    logic [OPND_W-1:0] r_dsr, n_dsr;
    logic              r_dneg, n_dneg;
    logic [CNT_W-1:0]  r_dcnt, n_dcnt;
    logic              div_load;
    logic signed [DATA_W-1:0] div_num;
    logic signed [OPND_W-1:0] div_den;

    // Multiplier operands.
    logic signed [OPND_W-1:0] mul_a, mul_b;
    logic [OPND_W-1:0]   mag_a, mag_b;
    logic [2*OPND_W-1:0] mul_full;
    logic [63:0]         mul_rnd;
    logic [QUO_W-1:0]    mul_p;
    logic                mul_neg;

    // Derived control values.
    logic accept, short_rng, p_more;
    logic [END_W-1:0] end_cl;
    logic signed [OPND_W-1:0] sum_vp, sum_vm, sum_cp, sum_mc, dif_pc, dif_mc, dif_cm;
    logic signed [OPND_W-1:0] abs_cr, abs_cl;
    logic signed [ACC_W-1:0]  div_q;

    assign accept    = start && !busy;
    assign end_cl    = (r_end > END_W'(CELLS)) ? END_W'(CELLS) : r_end;
    assign short_rng = (12'(r_start) + 12'd3) > 12'(end_cl);
    assign p_more    = (12'(r_i) + 12'd2) < 12'(end_cl);

    assign sum_vp = OPND_W'(r_uc) + OPND_W'(r_up);
    assign sum_vm = OPND_W'(r_uc) + OPND_W'(r_um);
    assign sum_cp = OPND_W'(r_tc) + OPND_W'(r_tp);
    assign sum_mc = OPND_W'(r_tm) + OPND_W'(r_tc);
    assign dif_pc = OPND_W'(r_tp) - OPND_W'(r_tc);
    assign dif_mc = OPND_W'(r_tm) - OPND_W'(r_tc);
    assign dif_cm = OPND_W'(r_tc) - OPND_W'(r_tm);
    assign abs_cr = r_cr[DATA_W-1] ? -OPND_W'(r_cr) : OPND_W'(r_cr);
    assign abs_cl = r_cl[DATA_W-1] ? -OPND_W'(r_cl) : OPND_W'(r_cl);

    // Shared sign-magnitude multiplier with round-to-nearest, registered into r_prod.
    assign mag_a    = mul_a[OPND_W-1] ? OPND_W'(-mul_a) : OPND_W'(mul_a);
    assign mag_b    = mul_b[OPND_W-1] ? OPND_W'(-mul_b) : OPND_W'(mul_b);
    assign mul_full = mag_a * mag_b;
    assign mul_rnd  = mul_full[63:0] + 64'h8000;
    assign mul_p    = mul_rnd[63:16];
    assign mul_neg  = mul_a[OPND_W-1] ^ mul_b[OPND_W-1];
    assign n_prod   = mul_neg ? -$signed({1'b0, mul_p}) : $signed({1'b0, mul_p});

    // Signed quotient of the divider.
    assign div_q = r_dneg ? -$signed(ACC_W'({1'b0, r_quo})) : $signed(ACC_W'({1'b0, r_quo}));

    // Ports.
    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_out_valid;
    assign o_res    = r_out;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= RST_SCALE;
            r_gain  <= RST_GAIN;
            r_start <= RST_START;
            r_end   <= RST_END;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SCALE: r_scale <= i_cfg_data;
                CFG_GAIN:  r_gain  <= i_cfg_data;
                CFG_START: r_start <= i_cfg_data[IDX_W-1:0];
                CFG_END:   r_end   <= i_cfg_data[END_W-1:0];
                default:   r_end   <= r_end;
            endcase
        end
    end

    // Cell memories: one write and one registered read per memory each cycle.
    always_ff @(posedge i_clk) begin
        if (tr_we) tr_mem[tr_waddr] <= tr_wdata;
        if (ve_we) ve_mem[i_cmd.cell_index] <= i_cmd.velocity_in;
        if (up_we) up_mem[up_waddr] <= up_wdata;
        if (df_we) begin
            dr_mem[r_i] <= r_ra;
            dl_mem[r_i] <= r_la;
        end
        r_rd_t  <= tr_mem[rd_addr];
        r_rd_v  <= ve_mem[rd_addr];
        r_rd_u  <= up_mem[rd_addr];
        r_rd_dr <= dr_mem[r_i];
        r_rd_dl <= dl_mem[r_i];
    end

    // Restoring divider, one quotient bit per cycle.
    always_comb begin
        logic [REM_W-1:0]  rem_sh;
        logic [DATA_W-1:0] mag_n;
        logic [OPND_W-1:0] mag_d;
        rem_sh = {r_rem[REM_W-2:0], r_dvd[QUO_W-1]};
        mag_n  = div_num[DATA_W-1] ? DATA_W'(-div_num) : DATA_W'(div_num);
        mag_d  = div_den[OPND_W-1] ? OPND_W'(-div_den) : OPND_W'(div_den);
        n_dvd  = r_dvd;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        n_dneg = r_dneg;
        n_dcnt = r_dcnt;
        if (div_load) begin
            n_dvd  = {mag_n, 16'h0000} + QUO_W'(mag_d >> 1);
            n_quo  = '0;
            n_rem  = '0;
            n_dsr  = mag_d;
            n_dneg = div_num[DATA_W-1] ^ div_den[OPND_W-1];
            n_dcnt = CNT_W'(QUO_W);
        end else if (r_dcnt != '0) begin
            n_dvd  = {r_dvd[QUO_W-2:0], 1'b0};
            n_dcnt = r_dcnt - CNT_W'(1);
            if (rem_sh >= REM_W'(r_dsr)) begin
                n_rem = rem_sh - REM_W'(r_dsr);
                n_quo = {r_quo[QUO_W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh;
                n_quo = {r_quo[QUO_W-2:0], 1'b0};
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_cmd.opcode)
                        OP_STEP: n_state = short_rng ? S_DONE : S_P1_RD0;
                        OP_READ: n_state = S_RD_OUT;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_RD_OUT:  n_state = S_IDLE;
            S_DONE:    n_state = S_IDLE;
            S_P1_RD0:  n_state = S_P1_RD1;
            S_P1_RD1:  n_state = S_P1_RD2;
            S_P1_RD2:  n_state = S_P1_CAP;
            S_P1_CAP:  n_state = S_A1;
            S_A1:      n_state = S_A2;
            S_A2:      n_state = S_A3;
            S_A3:      n_state = S_A4;
            S_A4:      n_state = S_A5;
            S_A5:      n_state = S_A6;
            S_A6:      n_state = S_A7;
            S_A7:      n_state = S_P1_NEXT;
            S_P1_NEXT: n_state = p_more ? S_P1_CAP : S_P2_RD0;
            S_P2_RD0:  n_state = S_P2_RD1;
            S_P2_RD1:  n_state = S_P2_RD2;
            S_P2_RD2:  n_state = S_P2_CAP;
            S_P2_CAP:  n_state = S_C1;
            S_C1:      n_state = S_C2;
            S_C2:      n_state = S_C3;
            S_C3:      n_state = S_DIV_R;
            S_DIV_R:   n_state = (r_dcnt == '0) ? S_DIV_L : S_DIV_R;
            S_DIV_L:   n_state = (r_dcnt == '0) ? S_C5 : S_DIV_L;
            S_C5:      n_state = S_C6;
            S_C6:      n_state = S_C7;
            S_C7:      n_state = S_C8;
            S_C8:      n_state = S_C9;
            S_C9:      n_state = S_P2_NEXT;
            S_P2_NEXT: n_state = p_more ? S_P2_CAP : S_DONE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Datapath control and register next values.
    always_comb begin
        t_sat s;
        s = '0;
        n_i = r_i;
        n_tm = r_tm; n_tc = r_tc; n_tp = r_tp;
        n_um = r_um; n_uc = r_uc; n_up = r_up;
        n_cr = r_cr; n_cl = r_cl; n_ra = r_ra; n_la = r_la;
        n_acc = r_acc;
        n_sat = r_sat;
        n_out_valid = 1'b0;
        n_out = r_out;
        rd_addr = r_i;
        tr_we = 1'b0; tr_waddr = r_i; tr_wdata = i_cmd.tracer_in;
        ve_we = 1'b0;
        up_we = 1'b0; up_waddr = r_i; up_wdata = r_rd_t;
        df_we = 1'b0;
        div_load = 1'b0; div_num = r_ra; div_den = sum_cp;
        mul_a = '0; mul_b = '0;
        case (r_state)
            S_IDLE: begin
                rd_addr = i_cmd.cell_index;
                if (accept) begin
                    case (i_cmd.opcode)
                        OP_WRITE: begin
                            tr_we = 1'b1;
                            tr_waddr = i_cmd.cell_index;
                            ve_we = 1'b1;
                        end
                        OP_STEP: begin
                            n_sat = 1'b0;
                            n_i = r_start;
                        end
                        default: n_i = r_i;
                    endcase
                end
            end
            S_RD_OUT: begin
                n_out_valid = 1'b1;
                n_out = '{result_kind: KIND_READ, tracer_out: r_rd_t, saturated: r_sat};
            end
            S_DONE: begin
                n_out_valid = 1'b1;
                n_out = '{result_kind: KIND_STEP, tracer_out: '0, saturated: r_sat};
            end
            // First pass: fill the three-cell window of tracer and velocity.
            S_P1_RD1: begin
                n_tc = r_rd_t;
                n_uc = r_rd_v;
                up_we = 1'b1;
                rd_addr = r_i + ADDR_W'(1);
                n_i = r_i + ADDR_W'(1);
            end
            S_P1_RD2: begin
                n_tm = r_tc; n_um = r_uc;
                n_tc = r_rd_t; n_uc = r_rd_v;
                rd_addr = r_i + ADDR_W'(1);
            end
            S_P1_CAP: begin
                n_tp = r_rd_t;
                n_up = r_rd_v;
            end
            // Face Courant numbers, diffusivities and the upstream update.
            S_A1: begin
                mul_a = sum_vp;
                mul_b = $signed({1'b0, r_scale});
            end
            S_A2: begin
                s = sat32(ACC_W'(r_prod));
                n_cr = s.val;
                n_sat = r_sat | s.clip;
                mul_a = sum_vm;
                mul_b = $signed({1'b0, r_scale});
            end
            S_A3: begin
                s = sat32(ACC_W'(r_prod));
                n_cl = s.val;
                n_sat = r_sat | s.clip;
                mul_a = OPND_W'(r_cr);
                mul_b = OPND_W'(r_cr);
            end
            S_A4: begin
                s = sat32(ACC_W'(abs_cr) - ACC_W'(r_prod));
                n_ra = s.val;
                n_sat = r_sat | s.clip;
                mul_a = OPND_W'(r_cl);
                mul_b = OPND_W'(r_cl);
            end
            S_A5: begin
                s = sat32(ACC_W'(abs_cl) - ACC_W'(r_prod));
                n_la = s.val;
                n_sat = r_sat | s.clip;
                n_acc = ACC_W'(r_tc);
                mul_a = OPND_W'(r_cr);
                mul_b = dif_pc;
            end
            S_A6: begin
                if (r_cr <= 0) n_acc = r_acc - ACC_W'(r_prod);
                mul_a = OPND_W'(r_cl);
                mul_b = dif_mc;
            end
            S_A7: begin
                s = sat32((r_cl > 0) ? (r_acc + ACC_W'(r_prod)) : r_acc);
                n_sat = r_sat | s.clip;
                up_we = 1'b1;
                up_wdata = s.val;
                df_we = 1'b1;
            end
            S_P1_NEXT: begin
                if (p_more) begin
                    n_tm = r_tc; n_tc = r_tp;
                    n_um = r_uc; n_uc = r_up;
                    rd_addr = r_i + ADDR_W'(2);
                    n_i = r_i + ADDR_W'(1);
                end else begin
                    // Right boundary cell keeps its tracer value.
                    up_we = 1'b1;
                    up_waddr = r_i + ADDR_W'(1);
                    up_wdata = r_tp;
                    n_i = r_start;
                end
            end
            // Second pass: window over the upstream values.
            S_P2_RD1: begin
                n_tc = r_rd_u;
                rd_addr = r_i + ADDR_W'(1);
                n_i = r_i + ADDR_W'(1);
            end
            S_P2_RD2: begin
                n_tm = r_tc;
                n_tc = r_rd_u;
                rd_addr = r_i + ADDR_W'(1);
            end
            S_P2_CAP: begin
                n_tp = r_rd_u;
            end
            // Antidiffusive numerators.
            S_C1: begin
                mul_a = OPND_W'(r_rd_dr);
                mul_b = dif_pc;
            end
            S_C2: begin
                s = sat32(ACC_W'(r_prod));
                n_ra = s.val;
                n_sat = r_sat | s.clip;
                mul_a = OPND_W'(r_rd_dl);
                mul_b = dif_cm;
            end
            S_C3: begin
                s = sat32(ACC_W'(r_prod));
                n_la = s.val;
                n_sat = r_sat | s.clip;
                div_load = 1'b1;
            end
            // Antidiffusive velocities; a zero neighbor sum gives zero.
            S_DIV_R: begin
                if (r_dcnt == '0) begin
                    if (sum_cp == '0) begin
                        n_cr = '0;
                    end else begin
                        s = sat32(div_q);
                        n_cr = s.val;
                        n_sat = r_sat | s.clip;
                    end
                    div_load = 1'b1;
                    div_num = r_la;
                    div_den = sum_mc;
                end
            end
            S_DIV_L: begin
                if (r_dcnt == '0) begin
                    if (sum_mc == '0) begin
                        n_cl = '0;
                    end else begin
                        s = sat32(div_q);
                        n_cl = s.val;
                        n_sat = r_sat | s.clip;
                    end
                end
            end
            // Face fluxes and the corrected tracer.
            S_C5: begin
                mul_a = OPND_W'(r_cr);
                mul_b = (r_cr > 0) ? OPND_W'(r_tc) : OPND_W'(r_tp);
            end
            S_C6: begin
                n_acc = ACC_W'(r_prod);
                mul_a = OPND_W'(r_cl);
                mul_b = (r_cl > 0) ? OPND_W'(r_tm) : OPND_W'(r_tc);
            end
            S_C7: begin
                s = sat32(ACC_W'(r_prod) - r_acc);
                n_ra = s.val;
                n_sat = r_sat | s.clip;
            end
            S_C8: begin
                mul_a = OPND_W'(r_ra);
                mul_b = $signed({1'b0, r_gain});
            end
            S_C9: begin
                s = sat32(ACC_W'(r_tc) + ACC_W'(r_prod));
                n_sat = r_sat | s.clip;
                tr_we = 1'b1;
                tr_wdata = s.val;
            end
            S_P2_NEXT: begin
                if (p_more) begin
                    n_tm = r_tc;
                    n_tc = r_tp;
                    rd_addr = r_i + ADDR_W'(2);
                    n_i = r_i + ADDR_W'(1);
                end
            end
            default: n_i = r_i;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
            r_dcnt      <= '0;
        end else begin
            r_state     <= n_state;
            r_sat       <= n_sat;
            r_out_valid <= n_out_valid;
            r_dcnt      <= n_dcnt;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_tm   <= n_tm;  r_tc <= n_tc;  r_tp <= n_tp;
        r_um   <= n_um;  r_uc <= n_uc;  r_up <= n_up;
        r_cr   <= n_cr;  r_cl <= n_cl;  r_ra <= n_ra;  r_la <= n_la;
        r_acc  <= n_acc;
        r_prod <= n_prod;
        r_out  <= n_out;
        r_dvd  <= n_dvd;
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_dsr  <= n_dsr;
        r_dneg <= n_dneg;
    end

endmodule

[rtl/umad_chk.sv]
// Port-level checker for the advection block, attached by the bind at the end of this file.
// Depends on umad_pkg and on upstream_mpdata_advection_1d.
module umad_chk
    import umad_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input t_cmd i_cmd,
    input logic o_strobe,
    input t_res o_res
);

    // A result beat always follows a cycle in which the block was busy.
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result beat without a busy cycle before it");

    // Writes and unused codes finish at once and give no result.
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd.opcode == OP_WRITE || i_cmd.opcode == OP_NOP))
        |=> (!busy && !o_strobe))
        else $error("write command left the block busy or gave a result");

    // Reads and steps occupy the block.
    a_cmd_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd.opcode == OP_STEP || i_cmd.opcode == OP_READ)) |=> busy)
        else $error("read or step command did not make the block busy");

    // A finished step carries a zero tracer value.
    a_step_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.result_kind == KIND_STEP) |-> (o_res.tracer_out == '0))
        else $error("step result with nonzero tracer value");

    // Result beats never come in consecutive cycles.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("two result beats in a row");

endmodule

bind upstream_mpdata_advection_1d umad_chk u_umad_chk (.*);
